// File: design/prc_pkg.sv
// ----------------------------------------------------------------------------
// prc_pkg
// Shared types, codes and helpers for the packet rule classifier.
// ----------------------------------------------------------------------------
package prc_pkg;

    localparam int CNT_W        = 64;
    localparam int NUM_BASE_CNT = 6;   // packets, four verdicts, bytes

    // command codes
    localparam logic [1:0] CMD_CLASSIFY = 2'd0;
    localparam logic [1:0] CMD_WRITE    = 2'd1;
    localparam logic [1:0] CMD_READ     = 2'd2;

    // class action codes
    localparam logic [1:0] ACT_PASS     = 2'd0;
    localparam logic [1:0] ACT_DROP     = 2'd1;
    localparam logic [1:0] ACT_MARK     = 2'd2;
    localparam logic [1:0] ACT_REDIRECT = 2'd3;

    // verdict codes
    localparam logic [1:0] VERDICT_PASS     = 2'd0;
    localparam logic [1:0] VERDICT_DROP     = 2'd1;
    localparam logic [1:0] VERDICT_REDIRECT = 2'd2;
    localparam logic [1:0] VERDICT_ACK      = 2'd3;

    // config register indexes
    localparam logic [2:0] CFG_SRC_ADDR = 3'd0;
    localparam logic [2:0] CFG_SRC_MASK = 3'd1;
    localparam logic [2:0] CFG_DST_ADDR = 3'd2;
    localparam logic [2:0] CFG_DST_MASK = 3'd3;
    localparam logic [2:0] CFG_SRC_PORT = 3'd4;
    localparam logic [2:0] CFG_DST_PORT = 3'd5;
    localparam logic [2:0] CFG_PROTOCOL = 3'd6;
    localparam logic [2:0] CFG_CLASS    = 3'd7;

    typedef struct packed {
        logic [1:0]  cmd;
        logic        is_ipv4;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [7:0]  ip_protocol;
        logic [15:0] l4_src_port;
        logic [15:0] l4_dst_port;
        logic [15:0] frame_length;
        logic [6:0]  entry_index;
        logic        entry_valid;
        logic [1:0]  entry_action;
        logic [31:0] entry_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       verdict;
        logic             set_index;
        logic [15:0]      index_value;
        logic [31:0]      redirect_port;
        logic [CNT_W-1:0] counter_value;
    } t_out_item;

    typedef struct packed {
        logic        present;
        logic [1:0]  action;
        logic [31:0] operand;
    } t_class_entry;

    typedef enum logic [1:0] {
        KIND_PASS,
        KIND_DROP,
        KIND_MARK,
        KIND_REDIRECT
    } t_kind;

    typedef enum logic [2:0] {
        SEL_PKT,
        SEL_PASS,
        SEL_DROP,
        SEL_MARK,
        SEL_REDIR,
        SEL_BYTES,
        SEL_RULE,
        SEL_NONE
    } t_stat_sel;

    typedef struct packed {
        logic        en;
        t_kind       kind;
        logic        hit;
        logic [15:0] len;
    } t_stat_upd;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [15:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {{(CNT_W-15){1'b0}}, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

endpackage

// File: design/prc_vmem.sv
// ----------------------------------------------------------------------------
// prc_vmem
// Single-port-write / single-read synchronous memory with a registered read port.
// Per-entry valid bits cleared by reset; an unwritten entry reads as zero.
// ----------------------------------------------------------------------------
module prc_vmem #(
    parameter int WIDTH = 35,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [WIDTH-1:0] r_rd_data;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// File: design/prc_stats.sv
// ----------------------------------------------------------------------------
// prc_stats
// Scalar saturating counters: packets, bytes, four verdicts, rule hits.
// ----------------------------------------------------------------------------
module prc_stats
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  prc_pkg::t_stat_upd      i_upd,
    input  prc_pkg::t_stat_sel      i_sel,
    output logic [prc_pkg::CNT_W-1:0] o_value
);
    import prc_pkg::*;

    logic [CNT_W-1:0] r_pkt;
    logic [CNT_W-1:0] r_bytes;
    logic [CNT_W-1:0] r_rule;
    logic [CNT_W-1:0] r_vcnt [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt   <= '0;
            r_bytes <= '0;
            r_rule  <= '0;
            for (int k = 0; k < 4; k++) begin
                r_vcnt[k] <= '0;
            end
        end else if (i_upd.en) begin
            r_pkt   <= sat_add(r_pkt, 16'd1);
            r_bytes <= sat_add(r_bytes, i_upd.len);
            if (i_upd.hit) begin
                r_rule <= sat_add(r_rule, 16'd1);
            end
            for (int k = 0; k < 4; k++) begin
                if (i_upd.kind == t_kind'(k)) begin
                    r_vcnt[k] <= sat_add(r_vcnt[k], 16'd1);
                end
            end
        end
    end

    always_comb begin
        case (i_sel)
            SEL_PKT:   o_value = r_pkt;
            SEL_PASS:  o_value = r_vcnt[0];
            SEL_DROP:  o_value = r_vcnt[1];
            SEL_MARK:  o_value = r_vcnt[2];
            SEL_REDIR: o_value = r_vcnt[3];
            SEL_BYTES: o_value = r_bytes;
            SEL_RULE:  o_value = r_rule;
            default:   o_value = '0;
        endcase
    end

endmodule

// File: design/packet_rule_classifier_top.sv
// ----------------------------------------------------------------------------
// packet_rule_classifier_top
// One-rule five-tuple classifier with class table and saturating statistics.
// ----------------------------------------------------------------------------
// For each input transaction, in the accept cycle the class table and the
// per-class hit counter memory are read into registered read ports, and
// in the execute state the rule compare, the class action and the
// read-modify-write of the hit counter finish and the result is loaded into
// the output register. A new transaction is accepted as soon as the block is
// back in idle, even while the previous result still waits in the output
// register; the execute cycle stretches only while that register is full and
// stalled. The two memories have reset-cleared valid bits, so no clearing
// pass is needed after reset. Configuration writes are always ready and must
// only be issued while the block is idle.
// ----------------------------------------------------------------------------
module packet_rule_classifier_top #(
    parameter int CLASS_ENTRIES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // item channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  prc_pkg::t_in_item   i_in,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output prc_pkg::t_out_item  o_out,
    // configuration write channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    import prc_pkg::*;

    localparam int AW       = (CLASS_ENTRIES > 1) ? $clog2(CLASS_ENTRIES) : 1;
    localparam int CE_W     = $bits(t_class_entry);
    localparam int RULE_CNT = NUM_BASE_CNT + CLASS_ENTRIES;

    // configuration registers
    logic [31:0] r_src_addr, r_src_mask, r_dst_addr, r_dst_mask;
    logic [15:0] r_src_port, r_dst_port;
    logic [7:0]  r_protocol, r_class;

    t_state      r_state, n_state;
    t_in_item    r_item;
    logic        r_out_vld;
    t_out_item   r_out;

    logic        w_accept;
    logic        w_finish;

    // memory ports
    logic [AW-1:0]    w_cls_rd_addr, w_hit_rd_addr, w_hit_wr_addr;
    logic             w_cls_we, w_hit_we;
    t_class_entry     w_cls_wr, w_cls_rd;
    logic [CE_W-1:0]  w_cls_rd_raw;
    logic [CNT_W-1:0] w_hit_rd, w_hit_wr;
    logic [8:0]       w_in_cnt_off;

    // execute-cycle decode
    logic             w_cls_ok, w_match;
    logic [8:0]       w_idx9;
    t_kind            w_kind;
    logic             w_hit;
    t_stat_upd        w_upd;
    t_stat_sel        w_sel;
    logic [CNT_W-1:0] w_stat_val;
    t_out_item        w_result;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_addr <= '0;
            r_src_mask <= '0;
            r_dst_addr <= '0;
            r_dst_mask <= '0;
            r_src_port <= '0;
            r_dst_port <= '0;
            r_protocol <= '0;
            r_class    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SRC_ADDR: r_src_addr <= i_cfg_data;
                CFG_SRC_MASK: r_src_mask <= i_cfg_data;
                CFG_DST_ADDR: r_dst_addr <= i_cfg_data;
                CFG_DST_MASK: r_dst_mask <= i_cfg_data;
                CFG_SRC_PORT: r_src_port <= i_cfg_data[15:0];
                CFG_DST_PORT: r_dst_port <= i_cfg_data[15:0];
                CFG_PROTOCOL: r_protocol <= i_cfg_data[7:0];
                CFG_CLASS:    r_class    <= i_cfg_data[7:0];
                default:      r_class    <= r_class;
            endcase
        end
    end

    // ---------------- control FSM ----------------
    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        w_finish   = (r_state == S_EXEC) && (!r_out_vld || !i_out_stall);
    end

    assign w_accept = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept) n_state = S_EXEC;
            S_EXEC:  if (w_finish) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in;
        end
    end

    // ---------------- memory reads at accept ----------------
    // Classify reads the rule's class; a counter read needs the hit counter.
    assign w_in_cnt_off  = {2'b00, i_in.entry_index} - 9'(NUM_BASE_CNT);
    assign w_cls_rd_addr = r_class[AW-1:0];
    assign w_hit_rd_addr = (i_in.cmd == CMD_CLASSIFY) ? r_class[AW-1:0]
                                                      : w_in_cnt_off[AW-1:0];

    prc_vmem #(
        .WIDTH (CE_W),
        .DEPTH (CLASS_ENTRIES)
    ) u_class_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_cls_rd_addr),
        .i_we      (w_cls_we),
        .i_wr_addr (w_idx9[AW-1:0]),
        .i_wr_data (w_cls_wr),
        .o_rd_data (w_cls_rd_raw)
    );

    assign w_cls_rd = t_class_entry'(w_cls_rd_raw);

    prc_vmem #(
        .WIDTH (CNT_W),
        .DEPTH (CLASS_ENTRIES)
    ) u_hit_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_hit_rd_addr),
        .i_we      (w_hit_we),
        .i_wr_addr (w_hit_wr_addr),
        .i_wr_data (w_hit_wr),
        .o_rd_data (w_hit_rd)
    );

    // ---------------- execute ----------------
    // Rule compare; config must stay stable while a transaction is in flight (not enforced here).
    assign w_cls_ok = ({1'b0, r_class} < 9'(CLASS_ENTRIES));
    assign w_match  = r_item.is_ipv4
                   && ((r_item.src_addr & r_src_mask) == (r_src_addr & r_src_mask))
                   && ((r_item.dst_addr & r_dst_mask) == (r_dst_addr & r_dst_mask))
                   && (r_src_port == '0 || r_item.l4_src_port == r_src_port)
                   && (r_dst_port == '0 || r_item.l4_dst_port == r_dst_port)
                   && (r_protocol == '0 || r_item.ip_protocol == r_protocol)
                   && w_cls_ok && w_cls_rd.present;

    always_comb begin
        w_kind = KIND_PASS;
        if (w_match) begin
            case (w_cls_rd.action)
                ACT_DROP:     w_kind = KIND_DROP;
                ACT_MARK:     w_kind = KIND_MARK;
                ACT_REDIRECT: w_kind = (w_cls_rd.operand != '0) ? KIND_REDIRECT
                                                                : KIND_PASS;
                default:      w_kind = KIND_PASS;
            endcase
        end
    end

    assign w_hit = (w_kind != KIND_PASS);

    // hit counter read-modify-write; reads and writes never share a cycle
    assign w_hit_we      = w_finish && (r_item.cmd == CMD_CLASSIFY) && w_hit;
    assign w_hit_wr_addr = r_class[AW-1:0];
    assign w_hit_wr      = sat_add(w_hit_rd, 16'd1);

    // class table write; an invalid write clears the entry
    assign w_cls_we = w_finish && (r_item.cmd == CMD_WRITE)
                   && ({2'b00, r_item.entry_index} < 9'(CLASS_ENTRIES));
    assign w_cls_wr = r_item.entry_valid
                    ? t_class_entry'{present: 1'b1,
                                     action:  r_item.entry_action,
                                     operand: r_item.entry_value}
                    : t_class_entry'('0);

    // statistics
    assign w_upd.en   = w_finish && (r_item.cmd == CMD_CLASSIFY);
    assign w_upd.kind = w_kind;
    assign w_upd.hit  = w_hit;
    assign w_upd.len  = r_item.frame_length;

    // counter number decode
    assign w_idx9 = {2'b00, r_item.entry_index};

    always_comb begin
        case (r_item.entry_index)
            7'd0:    w_sel = SEL_PKT;
            7'd1:    w_sel = SEL_PASS;
            7'd2:    w_sel = SEL_DROP;
            7'd3:    w_sel = SEL_MARK;
            7'd4:    w_sel = SEL_REDIR;
            7'd5:    w_sel = SEL_BYTES;
            default: w_sel = (w_idx9 == 9'(RULE_CNT)) ? SEL_RULE : SEL_NONE;
        endcase
    end

    prc_stats u_stats (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (w_upd),
        .i_sel   (w_sel),
        .o_value (w_stat_val)
    );

    // result
    always_comb begin
        w_result = '0;
        case (r_item.cmd)
            CMD_CLASSIFY: begin
                case (w_kind)
                    KIND_DROP:     w_result.verdict = VERDICT_DROP;
                    KIND_REDIRECT: w_result.verdict = VERDICT_REDIRECT;
                    default:       w_result.verdict = VERDICT_PASS;
                endcase
                if (w_kind == KIND_MARK) begin
                    w_result.set_index   = 1'b1;
                    w_result.index_value = w_cls_rd.operand[15:0];
                end
                if (w_kind == KIND_REDIRECT) begin
                    w_result.redirect_port = w_cls_rd.operand;
                end
            end
            CMD_READ: begin
                w_result.verdict = VERDICT_ACK;
                if (w_idx9 >= 9'(NUM_BASE_CNT) && w_idx9 < 9'(RULE_CNT)) begin
                    w_result.counter_value = w_hit_rd;
                end else begin
                    w_result.counter_value = w_stat_val;
                end
            end
            default: w_result.verdict = VERDICT_ACK;
        endcase
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_finish) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    // ---------------- assertions ----------------
    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_EXEC))
        else $error("accepted transaction did not enter execute");

    a_finish_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish |=> r_out_vld)
        else $error("finished transaction not presented");

    a_hit_only_classify: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hit_we |-> (r_item.cmd == CMD_CLASSIFY) && w_match)
        else $error("hit counter written without a rule match");

    a_redirect_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.verdict == VERDICT_REDIRECT) |-> (r_out.redirect_port != '0))
        else $error("redirect with zero port");

    a_mark_is_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.set_index) |-> (r_out.verdict == VERDICT_PASS))
        else $error("mark result with non-pass verdict");

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the packet rule classifier.
// ----------------------------------------------------------------------------
// Items are queued by the sequence process and pushed into the block by a
// bursty driver. Every accepted transaction runs through a cycle-free model
// of the classifier (rule compare, class table, saturating counters). The
// model's answer joins an in-order list that the monitor checks field by
// field against each accepted result. The rule registers are reloaded between
// phases, only after the block has drained.
// ----------------------------------------------------------------------------
module tb_top;
    import prc_pkg::*;

    localparam int CLASS_ENTRIES    = 64;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int RANDOM_PER_PHASE = 100;
    localparam int NUM_PHASES       = 9;
    localparam int HOLD_PHASE       = 4;
    localparam int HOLD_CYCLES      = 400;
    localparam int TAIL_CYCLES      = 8;
    localparam int MAX_PRINTED      = 40;

    // command code the block does not know; it must just acknowledge
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    // counter numbers for read commands
    localparam logic [6:0] CNT_PACKETS  = 7'd0;
    localparam logic [6:0] CNT_PASS     = 7'd1;
    localparam logic [6:0] CNT_REDIRECT = 7'd4;
    localparam logic [6:0] CNT_BYTES    = 7'd5;
    localparam logic [6:0] CNT_CLASS0   = 7'(NUM_BASE_CNT);
    localparam logic [6:0] CNT_RULE     = 7'(NUM_BASE_CNT + CLASS_ENTRIES);
    localparam logic [6:0] CNT_LAST     = 7'h7F;

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in        = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data  = '0;

    packet_rule_classifier_top #(
        .CLASS_ENTRIES (CLASS_ENTRIES)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Classifier model state: rule, class table and statistics
    // ------------------------------------------------------------------------
    logic [31:0]  rule_src_addr = '0;
    logic [31:0]  rule_src_mask = '0;
    logic [31:0]  rule_dst_addr = '0;
    logic [31:0]  rule_dst_mask = '0;
    logic [15:0]  rule_src_port = '0;
    logic [15:0]  rule_dst_port = '0;
    logic [7:0]   rule_protocol = '0;
    logic [7:0]   rule_class    = '0;

    t_class_entry class_tab [CLASS_ENTRIES]     = '{default: '0};
    logic [63:0]  class_hit_cnt [CLASS_ENTRIES] = '{default: '0};
    logic [63:0]  verdict_cnt [4]               = '{default: '0};
    logic [63:0]  pkt_count                     = '0;
    logic [63:0]  byte_count                    = '0;
    logic [63:0]  rule_hit_cnt                  = '0;

    // transactions waiting to be offered, and answers waiting to be seen
    t_in_item  item_backlog [$];
    t_out_item pending_verdicts [$];

    // knobs for the sender and receiver, changed at negedge
    bit gaps_on        = 1'b0;
    int recv_stall_pct = 0;
    bit hold_on        = 1'b0;

    int err_count       = 0;
    int items_taken     = 0;
    int results_checked = 0;
    int settings_loaded = 0;
    int cycle_count     = 0;

    function automatic logic [63:0] bump_sat(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    // Applies one transaction to the model and returns the result it owes.
    function automatic t_out_item classify_item(t_in_item it);
        t_out_item    r;
        t_kind        kind;
        t_class_entry ent;
        logic [6:0]   idx;
        r = '0;
        r.verdict = VERDICT_ACK;
        case (it.cmd)
            CMD_CLASSIFY: begin
                r.verdict  = VERDICT_PASS;
                kind       = KIND_PASS;
                pkt_count  = bump_sat(pkt_count, 64'd1);
                byte_count = bump_sat(byte_count, 64'(it.frame_length));
                // out-of-table class simply finds nothing
                ent = '0;
                if (rule_class < CLASS_ENTRIES)
                    ent = class_tab[rule_class];
                if (it.is_ipv4 && ent.present &&
                    (it.src_addr & rule_src_mask) == (rule_src_addr & rule_src_mask) &&
                    (it.dst_addr & rule_dst_mask) == (rule_dst_addr & rule_dst_mask) &&
                    (rule_src_port == '0 || it.l4_src_port == rule_src_port) &&
                    (rule_dst_port == '0 || it.l4_dst_port == rule_dst_port) &&
                    (rule_protocol == '0 || it.ip_protocol == rule_protocol)) begin
                    case (ent.action)
                        ACT_DROP: begin
                            kind      = KIND_DROP;
                            r.verdict = VERDICT_DROP;
                        end
                        ACT_MARK: begin
                            kind          = KIND_MARK;
                            r.set_index   = 1'b1;
                            r.index_value = ent.operand[15:0];
                        end
                        ACT_REDIRECT: begin
                            // port zero means no usable target: plain pass
                            if (ent.operand != '0) begin
                                kind            = KIND_REDIRECT;
                                r.verdict       = VERDICT_REDIRECT;
                                r.redirect_port = ent.operand;
                            end
                        end
                        default: ;
                    endcase
                    if (kind != KIND_PASS) begin
                        class_hit_cnt[rule_class] = bump_sat(class_hit_cnt[rule_class], 64'd1);
                        rule_hit_cnt = bump_sat(rule_hit_cnt, 64'd1);
                    end
                end
                verdict_cnt[kind] = bump_sat(verdict_cnt[kind], 64'd1);
            end
            CMD_WRITE: begin
                // slots beyond the table are acknowledged and dropped
                if (it.entry_index < CLASS_ENTRIES) begin
                    if (it.entry_valid)
                        class_tab[it.entry_index] = '{present: 1'b1,
                                                      action:  it.entry_action,
                                                      operand: it.entry_value};
                    else
                        class_tab[it.entry_index] = '0;
                end
            end
            CMD_READ: begin
                idx = it.entry_index;
                if (idx == CNT_PACKETS)
                    r.counter_value = pkt_count;
                else if (idx <= CNT_REDIRECT)
                    r.counter_value = verdict_cnt[idx - CNT_PASS];
                else if (idx == CNT_BYTES)
                    r.counter_value = byte_count;
                else if (idx < CNT_RULE)
                    r.counter_value = class_hit_cnt[idx - CNT_CLASS0];
                else if (idx == CNT_RULE)
                    r.counter_value = rule_hit_cnt;
            end
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------------
    function automatic t_in_item random_fields();
        t_in_item it;
        it.cmd          = 2'($urandom);
        it.is_ipv4      = 1'($urandom);
        it.src_addr     = $urandom;
        it.dst_addr     = $urandom;
        it.ip_protocol  = 8'($urandom);
        it.l4_src_port  = 16'($urandom);
        it.l4_dst_port  = 16'($urandom);
        it.frame_length = 16'($urandom);
        it.entry_index  = 7'($urandom);
        it.entry_valid  = 1'($urandom);
        it.entry_action = 2'($urandom);
        it.entry_value  = $urandom;
        return it;
    endfunction

    function automatic t_in_item mk_packet(logic ipv4, logic [31:0] sa, logic [31:0] da,
                                           logic [7:0] proto, logic [15:0] sp,
                                           logic [15:0] dp, logic [15:0] len);
        t_in_item it;
        it              = random_fields();
        it.cmd          = CMD_CLASSIFY;
        it.is_ipv4      = ipv4;
        it.src_addr     = sa;
        it.dst_addr     = da;
        it.ip_protocol  = proto;
        it.l4_src_port  = sp;
        it.l4_dst_port  = dp;
        it.frame_length = len;
        return it;
    endfunction

    function automatic t_in_item mk_write(logic [6:0] slot, logic present,
                                          logic [1:0] action, logic [31:0] value);
        t_in_item it;
        it              = random_fields();
        it.cmd          = CMD_WRITE;
        it.entry_index  = slot;
        it.entry_valid  = present;
        it.entry_action = action;
        it.entry_value  = value;
        return it;
    endfunction

    function automatic t_in_item mk_read(logic [6:0] counter_no);
        t_in_item it;
        it             = random_fields();
        it.cmd         = CMD_READ;
        it.entry_index = counter_no;
        return it;
    endfunction

    // Random traffic shaped around the current rule: most packets are built
    // to hit it (with an occasional single-bit miss), and table writes and
    // counter reads lean toward the rule's own class slot.
    function automatic t_in_item mixed_item();
        t_in_item it;
        int       sel;
        bit       class_in_table;
        sel            = $urandom_range(0, 99);
        class_in_table = (rule_class < CLASS_ENTRIES);
        it             = random_fields();
        if (sel < 55) begin
            it.cmd      = CMD_CLASSIFY;
            it.is_ipv4  = ($urandom_range(0, 9) != 0);
            it.src_addr = (rule_src_addr & rule_src_mask) | (it.src_addr & ~rule_src_mask);
            it.dst_addr = (rule_dst_addr & rule_dst_mask) | (it.dst_addr & ~rule_dst_mask);
            if (rule_src_port != '0) it.l4_src_port = rule_src_port;
            if (rule_dst_port != '0) it.l4_dst_port = rule_dst_port;
            if (rule_protocol != '0) it.ip_protocol = rule_protocol;
            case ($urandom_range(0, 11))
                0: it.src_addr    ^= 32'h1 << $urandom_range(0, 31);
                1: it.dst_addr    ^= 32'h1 << $urandom_range(0, 31);
                2: it.l4_src_port ^= 16'h1 << $urandom_range(0, 15);
                3: it.l4_dst_port ^= 16'h1 << $urandom_range(0, 15);
                4: it.ip_protocol ^= 8'h1 << $urandom_range(0, 7);
                default: ;
            endcase
        end else if (sel < 63) begin
            it.cmd = CMD_CLASSIFY;
        end else if (sel < 80) begin
            it.cmd = CMD_WRITE;
            if ($urandom_range(0, 9) < 4 && class_in_table)
                it.entry_index = rule_class[6:0];
            else if ($urandom_range(0, 9) < 8)
                it.entry_index = 7'($urandom_range(0, CLASS_ENTRIES - 1));
            it.entry_valid = ($urandom_range(0, 7) != 0);
            case ($urandom_range(0, 3))
                0: it.entry_value = '0;
                1: it.entry_value = $urandom_range(1, 300);
                default: ;
            endcase
        end else if (sel < 97) begin
            it.cmd = CMD_READ;
            case ($urandom_range(0, 9))
                0, 1, 2: if (class_in_table) it.entry_index = CNT_CLASS0 + rule_class[6:0];
                3, 4, 5: it.entry_index = 7'($urandom_range(CNT_PACKETS, CNT_BYTES));
                6:       it.entry_index = CNT_RULE;
                default: ;
            endcase
        end else begin
            it.cmd = CMD_UNKNOWN;
        end
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Configuration writes; only issued with the block drained
    // ------------------------------------------------------------------------
    task automatic write_rule_reg(input logic [2:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_SRC_ADDR: rule_src_addr = data;
            CFG_SRC_MASK: rule_src_mask = data;
            CFG_DST_ADDR: rule_dst_addr = data;
            CFG_DST_MASK: rule_dst_mask = data;
            CFG_SRC_PORT: rule_src_port = data[15:0];
            CFG_DST_PORT: rule_dst_port = data[15:0];
            CFG_PROTOCOL: rule_protocol = data[7:0];
            CFG_CLASS:    rule_class    = data[7:0];
            default: ;
        endcase
    endtask

    task automatic load_rule(input logic [31:0] sa, input logic [31:0] sm,
                             input logic [31:0] da, input logic [31:0] dm,
                             input logic [31:0] sp, input logic [31:0] dp,
                             input logic [31:0] proto, input logic [31:0] cls);
        write_rule_reg(CFG_SRC_ADDR, sa);
        write_rule_reg(CFG_SRC_MASK, sm);
        write_rule_reg(CFG_DST_ADDR, da);
        write_rule_reg(CFG_DST_MASK, dm);
        write_rule_reg(CFG_SRC_PORT, sp);
        write_rule_reg(CFG_DST_PORT, dp);
        write_rule_reg(CFG_PROTOCOL, proto);
        write_rule_reg(CFG_CLASS, cls);
        settings_loaded++;
    endtask

    function automatic logic [31:0] pick_mask();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return 32'hFFFF_FFFF << (32 - $urandom_range(0, 32));
            default: return $urandom;
        endcase
    endfunction

    // Narrow registers get junk in the unused upper data bits on purpose.
    task automatic random_rule();
        logic [31:0] sp;
        logic [31:0] dp;
        logic [31:0] proto;
        logic [31:0] cls;
        sp    = $urandom;
        dp    = $urandom;
        proto = $urandom;
        cls   = $urandom;
        if ($urandom_range(0, 1)) sp[15:0] = '0;
        if ($urandom_range(0, 1)) dp[15:0] = '0;
        case ($urandom_range(0, 3))
            0: proto[7:0] = '0;
            1: proto[7:0] = 8'd6;
            2: proto[7:0] = 8'd17;
            default: ;
        endcase
        if ($urandom_range(0, 99) < 85)
            cls[7:0] = 8'($urandom_range(0, CLASS_ENTRIES - 1));
        else
            cls[7:0] = 8'($urandom_range(CLASS_ENTRIES, 255));
        load_rule($urandom, pick_mask(), $urandom, pick_mask(), sp, dp, proto, cls);
    endtask

    task automatic wait_idle();
        while (item_backlog.size() != 0 || i_in_valid || pending_verdicts.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        if (err_count < MAX_PRINTED)
            $display("mismatch at result %0d: %s got %h expected %h",
                     results_checked, what, got, want);
        err_count++;
    endtask

    // ------------------------------------------------------------------------
    // Driver: bursts of transactions separated by random gaps. The model is
    // stepped at the edge where a transaction is accepted.
    // ------------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                pending_verdicts.push_back(classify_item(i_in));
                items_taken++;
            end
            // a stalled transaction stays put; otherwise pick what comes next
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (item_backlog.size() != 0) begin
                    i_in       <= item_backlog.pop_front();
                    i_in_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 15);
                        gap_left   = (gaps_on && $urandom_range(0, 2) != 0) ?
                                     $urandom_range(1, 8) : 0;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each accepted result, and stalls in runs of random
    // length. hold_on forces a long hold-off from the sequence process.
    // ------------------------------------------------------------------------
    int        stall_run   = 0;
    bit        stall_level = 1'b0;
    t_out_item want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_verdicts.size() == 0) begin
                    flag_mismatch("result with nothing pending", o_out.counter_value, '0);
                end else begin
                    want = pending_verdicts.pop_front();
                    if (o_out.verdict !== want.verdict)
                        flag_mismatch("verdict", 64'(o_out.verdict), 64'(want.verdict));
                    if (o_out.set_index !== want.set_index)
                        flag_mismatch("set_index", 64'(o_out.set_index),
                                      64'(want.set_index));
                    if (o_out.index_value !== want.index_value)
                        flag_mismatch("index_value", 64'(o_out.index_value),
                                      64'(want.index_value));
                    if (o_out.redirect_port !== want.redirect_port)
                        flag_mismatch("redirect_port", 64'(o_out.redirect_port),
                                      64'(want.redirect_port));
                    if (o_out.counter_value !== want.counter_value)
                        flag_mismatch("counter_value", o_out.counter_value,
                                      want.counter_value);
                end
                results_checked++;
            end
            if (stall_run > 0) begin
                stall_run--;
            end else begin
                stall_level = ($urandom_range(1, 100) <= recv_stall_pct);
                stall_run   = $urandom_range(0, 7);
            end
            i_out_stall <= stall_level || hold_on;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sequence: reset, directed checks, then randomized rule phases
    // ------------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Rule: 192.168.1.0/24 -> 10.0.0.1, any source port, dport 443, TCP,
        // class 5.
        load_rule(32'hC0A8_0100, 32'hFFFF_FF00, 32'h0A00_0001, 32'hFFFF_FFFF,
                  32'd0, 32'd443, 32'd6, 32'd5);
        @(negedge i_clk);
        gaps_on        = 1'b1;
        recv_stall_pct = 30;
        item_backlog.push_back(mk_read(CNT_PACKETS));
        // class slot still absent: matching packet passes
        item_backlog.push_back(mk_packet(1'b1, 32'hC0A8_0107, 32'h0A00_0001, 8'd6,
                                         16'd1234, 16'd443, 16'd64));
        item_backlog.push_back(mk_write(7'd5, 1'b1, ACT_DROP, 32'd0));
        item_backlog.push_back(mk_packet(1'b1, 32'hC0A8_01FE, 32'h0A00_0001, 8'd6,
                                         16'hFFFF, 16'd443, 16'hFFFF));
        // non-IPv4 frame skips the rule
        item_backlog.push_back(mk_packet(1'b0, 32'hC0A8_01FE, 32'h0A00_0001, 8'd6,
                                         16'hFFFF, 16'd443, 16'd60));
        // near misses: dport, masked source, protocol
        item_backlog.push_back(mk_packet(1'b1, 32'hC0A8_01FE, 32'h0A00_0001, 8'd6,
                                         16'd0, 16'd444, 16'd60));
        item_backlog.push_back(mk_packet(1'b1, 32'hC0A8_0207, 32'h0A00_0001, 8'd6,
                                         16'd0, 16'd443, 16'd60));
        item_backlog.push_back(mk_packet(1'b1, 32'hC0A8_0100, 32'h0A00_0001, 8'd17,
                                         16'd0, 16'd443, 16'd60));
        // mark takes the low half of the operand
        item_backlog.push_back(mk_write(7'd5, 1'b1, ACT_MARK, 32'hABCD_1234));
        item_backlog.push_back(mk_packet(1'b1, 32'hC0A8_0101, 32'h0A00_0001, 8'd6,
                                         16'd80, 16'd443, 16'd1500));
        // redirect to port zero degrades to pass
        item_backlog.push_back(mk_write(7'd5, 1'b1, ACT_REDIRECT, 32'd0));
        item_backlog.push_back(mk_packet(1'b1, 32'hC0A8_0101, 32'h0A00_0001, 8'd6,
                                         16'd80, 16'd443, 16'd1500));
        item_backlog.push_back(mk_write(7'd5, 1'b1, ACT_REDIRECT, 32'hFFFF_FFFF));
        item_backlog.push_back(mk_packet(1'b1, 32'hC0A8_0101, 32'h0A00_0001, 8'd6,
                                         16'd80, 16'd443, 16'd1500));
        item_backlog.push_back(mk_write(7'd5, 1'b1, ACT_PASS, 32'h55));
        item_backlog.push_back(mk_packet(1'b1, 32'hC0A8_0101, 32'h0A00_0001, 8'd6,
                                         16'd80, 16'd443, 16'd1500));
        // removing the slot clears it
        item_backlog.push_back(mk_write(7'd5, 1'b0, ACT_DROP, 32'hFFFF_FFFF));
        item_backlog.push_back(mk_packet(1'b1, 32'hC0A8_0101, 32'h0A00_0001, 8'd6,
                                         16'd80, 16'd443, 16'd1500));
        // writes past the table are acknowledged and ignored; the last slot takes one
        item_backlog.push_back(mk_write(7'd64, 1'b1, ACT_DROP, 32'd1));
        item_backlog.push_back(mk_write(CNT_LAST, 1'b1, ACT_DROP, 32'd1));
        item_backlog.push_back(mk_write(7'(CLASS_ENTRIES - 1), 1'b1, ACT_REDIRECT,
                                        32'hFFFF_FFFF));
        // all-ones word is the unknown command; all-zeros a bare packet
        item_backlog.push_back('1);
        item_backlog.push_back('0);
        item_backlog.push_back(mk_read(CNT_BYTES));
        item_backlog.push_back(mk_read(CNT_CLASS0 + 7'd5));
        item_backlog.push_back(mk_read(CNT_RULE));
        item_backlog.push_back(mk_read(CNT_LAST));
        wait_idle();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0:       load_rule('0, '0, '0, '0, '0, '0, '0, '0);
                1:       load_rule('1, '1, '1, '1, '1, '1, '1, '1);
                2:       load_rule('0, '0, '0, '0, '0, '0, '0, CLASS_ENTRIES - 1);
                default: random_rule();
            endcase
            @(negedge i_clk);
            // every third phase runs flat out on both sides
            gaps_on        = (ph % 3 != 0);
            recv_stall_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 30 : 75;
            repeat (RANDOM_PER_PHASE) item_backlog.push_back(mixed_item());
            if (ph == HOLD_PHASE) begin
                // receiver holds off while the sender keeps offering, so the
                // output register fills and the input side backs up
                hold_on = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_on = 1'b0;
            end
            wait_idle();
        end

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (pending_verdicts.size() != 0)
            flag_mismatch("results never seen", 64'(pending_verdicts.size()), '0);

        $display("summary: %0d transactions in, %0d results checked, %0d rule settings, %0d cycles",
                 items_taken, results_checked, settings_loaded, cycle_count);
        $display("summary: packets %0d -> pass %0d drop %0d mark %0d redirect %0d, rule hits %0d",
                 pkt_count, verdict_cnt[KIND_PASS], verdict_cnt[KIND_DROP],
                 verdict_cnt[KIND_MARK], verdict_cnt[KIND_REDIRECT], rule_hit_cnt);
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
